/* hdl/cap_pkg.sv */
// Package for the cascaded attitude controller.
// Holds the payload and configuration types, fixed widths and register indexes.
// No dependencies.
package cap_pkg;

    localparam int unsigned AW = 35;   // multiplier operand A width (signed)
    localparam int unsigned BW = 17;   // multiplier operand B width (signed)
    localparam int unsigned PW = AW + BW;
    localparam int unsigned TW = 64;   // PID sum accumulator width
    localparam int unsigned EW = 33;   // error before saturation
    localparam int unsigned CIW = 4;   // configuration index width

    localparam logic [CIW-1:0] REG_ROLL_ANGLE  = 4'd0;
    localparam logic [CIW-1:0] REG_PITCH_ANGLE = 4'd1;
    localparam logic [CIW-1:0] REG_ROLL_RATE   = 4'd2;
    localparam logic [CIW-1:0] REG_PITCH_RATE  = 4'd3;
    localparam logic [CIW-1:0] REG_YAW_RATE    = 4'd4;
    localparam logic [CIW-1:0] REG_PERIOD      = 4'd5;
    localparam logic [CIW-1:0] REG_RATE        = 4'd6;
    localparam logic [CIW-1:0] REG_LIMITS      = 4'd7;

    localparam logic [15:0] PERIOD_RESET = 16'd65;
    localparam logic [15:0] RATE_RESET   = 16'd1000;
    localparam logic [63:0] LIMITS_RESET = 64'h0C80_0640_1F40_0C80;

    typedef struct packed {
        logic signed [15:0] roll_setpoint;
        logic signed [15:0] pitch_setpoint;
        logic signed [15:0] yaw_rate_setpoint;
        logic signed [15:0] measured_roll;
        logic signed [15:0] measured_pitch;
        logic signed [15:0] roll_gyro;
        logic signed [15:0] pitch_gyro;
        logic signed [15:0] yaw_gyro;
    } t_in;

    typedef struct packed {
        logic signed [15:0] roll_drive;
        logic signed [15:0] pitch_drive;
        logic signed [15:0] yaw_drive;
    } t_out;

    typedef struct packed {
        logic [4:0][47:0] gains;
        logic [15:0]      period;
        logic [15:0]      rate;
        logic [63:0]      limits;
    } t_cfg;

endpackage

/* hdl/cap_cfg.sv */
// Configuration register file of the cascaded attitude controller.
// Decodes write beats by index and presents all settings as one struct. Uses cap_pkg.
module cap_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [cap_pkg::CIW-1:0] i_index,
    input  logic [63:0]           i_data,
    output cap_pkg::t_cfg         o_cfg
);
    import cap_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gains  <= '0;
            r_cfg.period <= PERIOD_RESET;
            r_cfg.rate   <= RATE_RESET;
            r_cfg.limits <= LIMITS_RESET;
        end else if (i_wr) begin
            case (i_index)
                REG_ROLL_ANGLE:  r_cfg.gains[0] <= i_data[47:0];
                REG_PITCH_ANGLE: r_cfg.gains[1] <= i_data[47:0];
                REG_ROLL_RATE:   r_cfg.gains[2] <= i_data[47:0];
                REG_PITCH_RATE:  r_cfg.gains[3] <= i_data[47:0];
                REG_YAW_RATE:    r_cfg.gains[4] <= i_data[47:0];
                REG_PERIOD:      r_cfg.period   <= i_data[15:0];
                REG_RATE:        r_cfg.rate     <= i_data[15:0];
                REG_LIMITS:      r_cfg.limits   <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/cap_mul.sv */
// Shared signed multiplier of the cascaded attitude controller.
// One registered product per cycle; widths from cap_pkg.
module cap_mul (
    input  logic                          i_clk,
    input  logic signed [cap_pkg::AW-1:0] i_a,
    input  logic signed [cap_pkg::BW-1:0] i_b,
    output logic signed [cap_pkg::PW-1:0] o_p
);
    import cap_pkg::*;

    logic signed [PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PW'(i_a) * PW'(i_b);
    end

    assign o_p = r_p;

endmodule

/* hdl/cascaded_attitude_pid.sv */
// Cascaded roll/pitch attitude controller with a yaw-rate loop, top level.
// Uses cap_pkg, cap_cfg and cap_mul.
//
// Usage: one input beat carries a full sample set (angle targets, yaw-rate
// target, measured angles, gyro rates). The block then runs five PID loops in
// turn: roll and pitch angle, then roll, pitch and yaw rate, all through a
// single shared multiplier under a small step sequencer. Each loop
// steps through the error, period, derivative, Kp, Ki, Kd and output states;
// after the last loop the done state hands the result to the output register.
// The sequencer then returns to idle before it can accept the next set, so a
// new set is not taken while one is still in work. o_in_ready is
// high only while the sequencer is idle. A finished result sits in the output
// register; a new sample set may be accepted while it waits, but the sequencer
// holds at the end of that set until the receiver has taken the earlier beat.
// Configuration beats are always accepted and must only be sent while idle.
// Reset clears the loop integrals, previous measurements and the output
// valid, and loads the configuration reset values.
module cascaded_attitude_pid #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  cap_pkg::t_in             i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output cap_pkg::t_out            o_out,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [cap_pkg::CIW-1:0]  i_cfg_index,
    input  logic [63:0]              i_cfg_data
);
    import cap_pkg::*;

    localparam int W = SAMPLE_WIDTH;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_MP   = 4'd2;
    localparam logic [3:0] S_MD   = 4'd3;
    localparam logic [3:0] S_MKP  = 4'd4;
    localparam logic [3:0] S_MKI  = 4'd5;
    localparam logic [3:0] S_MKD  = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    localparam logic signed [EW-1:0] ERR_HI = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] ERR_LO = ~ERR_HI;
    localparam logic signed [TW-1:0] RES_HI = {{(TW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [TW-1:0] RES_LO = ~RES_HI;
    localparam logic signed [EW-1:0] D16_HI = {{(EW-15){1'b0}}, {15{1'b1}}};
    localparam logic signed [EW-1:0] D16_LO = ~D16_HI;

    t_cfg cfg;

    logic [3:0]  r_step;
    logic [2:0]  r_loop;
    t_in         r_in;
    logic        r_out_valid;
    t_out        r_out;

    logic signed [W-1:0]  r_err;
    logic signed [31:0]   r_acc;
    logic signed [33:0]   r_deriv;
    logic signed [TW-1:0] r_tot;
    logic signed [W-1:0]  r_res [5];
    logic signed [31:0]   r_integ [5];
    logic signed [15:0]   r_prev [5];

    logic signed [EW-1:0] tgt, fb;
    logic signed [EW-1:0] diff;
    logic signed [15:0]   meas;
    logic [47:0]          gains;
    logic [15:0]          out_lim, int_lim;
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_sh;
    logic signed [49:0]   isum, ilim;
    logic signed [31:0]   acc_c;
    logic signed [TW-1:0] tot_f, tot_s, olim, res_c;
    logic signed [EW-1:0] d_roll, d_pitch, d_yaw;
    logic                 out_load;

    cap_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    cap_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // Operands of the loop now being worked on.
    always_comb begin
        case (r_loop)
            3'd0: begin
                tgt  = EW'(r_in.roll_setpoint);
                fb   = EW'(r_in.measured_roll);
                meas = r_in.measured_roll;
            end
            3'd1: begin
                tgt  = EW'(r_in.pitch_setpoint);
                fb   = EW'(r_in.measured_pitch);
                meas = r_in.measured_pitch;
            end
            3'd2: begin
                tgt  = EW'(r_res[0]);
                fb   = EW'(r_in.roll_gyro);
                meas = r_in.roll_gyro;
            end
            3'd3: begin
                tgt  = EW'(r_res[1]);
                fb   = EW'(r_in.pitch_gyro);
                meas = r_in.pitch_gyro;
            end
            default: begin
                tgt  = EW'(r_in.yaw_rate_setpoint);
                fb   = EW'(r_in.yaw_gyro);
                meas = r_in.yaw_gyro;
            end
        endcase
        gains   = (r_loop <= 3'd4) ? cfg.gains[r_loop] : '0;
        out_lim = (r_loop < 3'd2) ? cfg.limits[15:0]  : cfg.limits[31:16];
        int_lim = (r_loop < 3'd2) ? cfg.limits[47:32] : cfg.limits[63:48];
        diff    = tgt - fb;
    end

    always_comb begin
        case (r_step)
            S_MP: begin
                mul_a = AW'(r_err);
                mul_b = BW'({1'b0, cfg.period});
            end
            S_MD: begin
                mul_a = AW'(EW'(meas) - EW'(r_prev[r_loop]));
                mul_b = BW'({1'b0, cfg.rate});
            end
            S_MKP: begin
                mul_a = AW'(r_err);
                mul_b = BW'($signed(gains[15:0]));
            end
            S_MKI: begin
                mul_a = AW'(r_acc);
                mul_b = BW'($signed(gains[31:16]));
            end
            S_MKD: begin
                mul_a = AW'(r_deriv);
                mul_b = BW'($signed(gains[47:32]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Integral update, clamped symmetrically.
    always_comb begin
        prod_sh = prod >>> 4;
        isum    = 50'(r_integ[r_loop]) + 50'(prod_sh);
        ilim    = $signed({22'd0, int_lim, 12'd0});
        if (isum > ilim)       acc_c = ilim[31:0];
        else if (isum < -ilim) acc_c = 32'(-ilim);
        else                   acc_c = isum[31:0];
    end

    // Output of one loop: floor shift, output clamp, then saturation.
    always_comb begin
        tot_f = r_tot - $signed({prod, 12'd0});
        tot_s = tot_f >>> 20;
        olim  = $signed({48'd0, out_lim});
        if (tot_s > olim)       res_c = olim;
        else if (tot_s < -olim) res_c = -olim;
        else                    res_c = tot_s;
        if (res_c > RES_HI)      res_c = RES_HI;
        else if (res_c < RES_LO) res_c = RES_LO;
    end

    always_comb begin
        d_roll  = EW'(r_res[2]);
        d_pitch = EW'(r_res[3]);
        d_yaw   = EW'(r_res[4]);
        if (d_roll > D16_HI)       d_roll  = D16_HI;
        else if (d_roll < D16_LO)  d_roll  = D16_LO;
        if (d_pitch > D16_HI)      d_pitch = D16_HI;
        else if (d_pitch < D16_LO) d_pitch = D16_LO;
        if (d_yaw > D16_HI)        d_yaw   = D16_HI;
        else if (d_yaw < D16_LO)   d_yaw   = D16_LO;
    end

    // The finished set is loaded once the previous output beat has been taken.
    assign out_load = (r_step == S_DONE) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_loop      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_integ[i] <= '0;
                r_prev[i]  <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_step)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in   <= i_in;
                        r_loop <= '0;
                        r_step <= S_ERR;
                    end
                end
                S_ERR: begin
                    if (diff > ERR_HI)      r_err <= ERR_HI[W-1:0];
                    else if (diff < ERR_LO) r_err <= ERR_LO[W-1:0];
                    else                    r_err <= diff[W-1:0];
                    r_step <= S_MP;
                end
                S_MP: r_step <= S_MD;
                S_MD: begin
                    r_acc           <= acc_c;
                    r_integ[r_loop] <= acc_c;
                    r_prev[r_loop]  <= meas;
                    r_step          <= S_MKP;
                end
                S_MKP: begin
                    r_deriv <= prod[33:0];
                    r_step  <= S_MKI;
                end
                S_MKI: begin
                    r_tot  <= $signed({prod, 12'd0});
                    r_step <= S_MKD;
                end
                S_MKD: begin
                    r_tot  <= r_tot + TW'(prod);
                    r_step <= S_OUT;
                end
                S_OUT: begin
                    r_res[r_loop] <= res_c[W-1:0];
                    if (r_loop == 3'd4) begin
                        r_step <= S_DONE;
                    end else begin
                        r_loop <= r_loop + 3'd1;
                        r_step <= S_ERR;
                    end
                end
                S_DONE: begin
                    // Hold here until the previous output beat has been taken.
                    if (out_load) begin
                        r_out.roll_drive  <= d_roll[15:0];
                        r_out.pitch_drive <= d_pitch[15:0];
                        r_out.yaw_drive   <= d_yaw[15:0];
                        r_step            <= S_IDLE;
                    end
                end
                default: r_step <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_step == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

/* tb/sv/cascaded_attitude_pid_tb.sv */
// Self-checking testbench for the cascaded attitude controller.
// Predicts each drive beat from its own fixed-point copy of the five PID loops.
// Depends on cap_pkg and cascaded_attitude_pid.
module cascaded_attitude_pid_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cap_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 800;
    localparam int DRAIN_CYCLES   = 60;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in              i_in = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out             o_out;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CIW-1:0]   i_cfg_index = '0;
    logic [63:0]      i_cfg_data = '0;

    cascaded_attitude_pid DUT (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Controller copy: configuration and loop state.
    logic [47:0] loop_gains [5];
    logic [15:0] period_q16;
    logic [15:0] rate_hz;
    logic [63:0] limits_q4;
    longint      integ_q16 [5];
    longint      last_meas [5];

    t_in  sample_queue [$];
    t_out drive_queue  [$];
    int   errors = 0;
    bit   no_idle = 1'b0;
    bit   hold_request = 1'b0;
    int   in_gap = 0;
    int   out_stall = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    logic next_valid;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // One PID step; updates that loop's integral and previous measurement.
    function automatic longint pid_step(int idx, logic [47:0] g, longint err, longint meas,
                                        longint out_lim, longint int_lim);
        longint kp, ki, kd, acc, deriv, total;
        kp = longint'($signed(g[15:0]));
        ki = longint'($signed(g[31:16]));
        kd = longint'($signed(g[47:32]));
        acc = integ_q16[idx] + ((err * longint'(period_q16)) >>> 4);
        acc = clamp_sym(acc, int_lim * 4096);
        integ_q16[idx] = acc;
        deriv = (meas - last_meas[idx]) * longint'(rate_hz);
        last_meas[idx] = meas;
        total = kp * err * 4096 + ki * acc - kd * deriv * 4096;
        return sat16(clamp_sym(total >>> 20, out_lim));
    endfunction

    function automatic t_out predict_drives(t_in s);
        longint ang_out, rate_out, ang_int, rate_int, r_roll, r_pitch;
        t_out d;
        ang_out  = longint'(limits_q4[15:0]);
        rate_out = longint'(limits_q4[31:16]);
        ang_int  = longint'(limits_q4[47:32]);
        rate_int = longint'(limits_q4[63:48]);
        r_roll  = pid_step(0, loop_gains[0],
                           sat16(longint'(s.roll_setpoint) - longint'(s.measured_roll)),
                           longint'(s.measured_roll), ang_out, ang_int);
        r_pitch = pid_step(1, loop_gains[1],
                           sat16(longint'(s.pitch_setpoint) - longint'(s.measured_pitch)),
                           longint'(s.measured_pitch), ang_out, ang_int);
        d.roll_drive  = 16'(pid_step(2, loop_gains[2], sat16(r_roll - longint'(s.roll_gyro)),
                                     longint'(s.roll_gyro), rate_out, rate_int));
        d.pitch_drive = 16'(pid_step(3, loop_gains[3], sat16(r_pitch - longint'(s.pitch_gyro)),
                                     longint'(s.pitch_gyro), rate_out, rate_int));
        d.yaw_drive   = 16'(pid_step(4, loop_gains[4],
                                     sat16(longint'(s.yaw_rate_setpoint)
                                           - longint'(s.yaw_gyro)),
                                     longint'(s.yaw_gyro), rate_out, rate_int));
        return d;
    endfunction

    task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
        $display("mismatch on %s: got %0d expected %0d at %0t",
                 field, $signed(got), $signed(want), $realtime);
        errors++;
    endtask

    // Sample-set driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                drive_queue.push_back(predict_drives(i_in));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (sample_queue.size() > 0) begin
                    i_in <= sample_queue.pop_front();
                    next_valid = 1'b1;
                    if (!no_idle) in_gap = gap_len();
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // Drive monitor, receiver stalls and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (drive_queue.size() == 0) begin
                    $display("drive beat with nothing expected at %0t", $realtime);
                    errors++;
                end else begin
                    t_out want;
                    want = drive_queue.pop_front();
                    if (o_out.roll_drive !== want.roll_drive)
                        report_mismatch("roll_drive", o_out.roll_drive, want.roll_drive);
                    if (o_out.pitch_drive !== want.pitch_drive)
                        report_mismatch("pitch_drive", o_out.pitch_drive, want.pitch_drive);
                    if (o_out.yaw_drive !== want.yaw_drive)
                        report_mismatch("yaw_drive", o_out.yaw_drive, want.yaw_drive);
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!no_idle) out_stall = gap_len();
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("cascaded_attitude_pid_tb failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CIW-1:0] idx, logic [63:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_ROLL_ANGLE:  loop_gains[0] = data[47:0];
            REG_PITCH_ANGLE: loop_gains[1] = data[47:0];
            REG_ROLL_RATE:   loop_gains[2] = data[47:0];
            REG_PITCH_RATE:  loop_gains[3] = data[47:0];
            REG_YAW_RATE:    loop_gains[4] = data[47:0];
            REG_PERIOD:      period_q16 = data[15:0];
            REG_RATE:        rate_hz = data[15:0];
            REG_LIMITS:      limits_q4 = data;
            default: ;
        endcase
    endtask

    function automatic logic [15:0] rand_field();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h7FFF;
        if (r == 1) return 16'h8000;
        if (r < 4) return 16'($urandom);
        return 16'($urandom_range(0, 4000) - 2000);
    endfunction

    function automatic t_in rand_sample();
        t_in s;
        s = {rand_field(), rand_field(), rand_field(), rand_field(),
             rand_field(), rand_field(), rand_field(), rand_field()};
        return s;
    endfunction

    function automatic logic [15:0] rand_gain(int style);
        if (style == 0) return 16'($urandom);
        if (style == 1) return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
        return 16'($urandom_range(0, 1024) - 512);
    endfunction

    // style 0: full random, 1: extremes, 2: moderate working values
    task automatic configure(int style);
        logic [63:0] lim;
        for (int i = 0; i < 5; i++)
            write_reg(CIW'(i), {16'($urandom), rand_gain(style), rand_gain(style),
                                rand_gain(style)});
        case (style)
            1: begin
                write_reg(REG_PERIOD, {48'($urandom), ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0});
                write_reg(REG_RATE, {48'($urandom), ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0});
                for (int k = 0; k < 4; k++)
                    lim[k*16 +: 16] = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'hFFFF;
            end
            2: begin
                write_reg(REG_PERIOD, 64'($urandom_range(1, 2000)));
                write_reg(REG_RATE, 64'($urandom_range(1, 2000)));
                lim = LIMITS_RESET;
            end
            default: begin
                write_reg(REG_PERIOD, {$urandom, $urandom});
                write_reg(REG_RATE, {$urandom, $urandom});
                lim = {$urandom, $urandom};
            end
        endcase
        write_reg(REG_LIMITS, lim);
        // Indexes past the last register must be ignored.
        write_reg(CIW'($urandom_range(8, 15)), {$urandom, $urandom});
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (sample_queue.size() > 0 || i_in_valid || drive_queue.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_in s;
        for (int i = 0; i < 5; i++) begin
            loop_gains[i] = '0;
            integ_q16[i] = 0;
            last_meas[i] = 0;
        end
        period_q16 = PERIOD_RESET;
        rate_hz    = RATE_RESET;
        limits_q4  = LIMITS_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: zero gains, integrals still run.
        for (int i = 0; i < 3; i++) sample_queue.push_back(rand_sample());
        wait_idle();

        // Directed: field extremes under moderate gains.
        configure(2);
        sample_queue.push_back('0);
        sample_queue.push_back({8{16'h7FFF}});
        sample_queue.push_back({8{16'h8000}});
        s = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
        sample_queue.push_back(s);
        sample_queue.push_back(~s);
        sample_queue.push_back({16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001,
                                16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001});
        for (int i = 0; i < 6; i++) sample_queue.push_back({8{16'h7FFF}});
        for (int i = 0; i < 6; i++) sample_queue.push_back({8{16'h8000}});
        wait_idle();

        // Zero period, zero rate and zero limits.
        write_reg(REG_PERIOD, 64'h0);
        write_reg(REG_RATE, 64'h0);
        write_reg(REG_LIMITS, 64'h0);
        for (int i = 0; i < 4; i++) sample_queue.push_back(rand_sample());
        wait_idle();

        // Random phases with varied settings, the sender pausing between them.
        for (int p = 0; p < 14; p++) begin
            configure((p % 4 == 3) ? 0 : (p % 4 == 1) ? 1 : 2);
            no_idle = (p % 5 == 2);
            for (int i = 0; i < 130; i++) sample_queue.push_back(rand_sample());
            if (p == 4) hold_request = 1'b1;
            wait_idle();
        end
        no_idle = 1'b0;

        if (drive_queue.size() == 0 && errors == 0) begin
            $display("cascaded_attitude_pid_tb passed");
        end else begin
            $display("cascaded_attitude_pid_tb failed");
        end
        $finish;
    end
endmodule
